FILE: rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared types and codes
// opcode fields, flag positions and the structs that pass between the
// execute logic, the return stack and the top level
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  // instruction groups, bits 13..12
  localparam logic [1:0] GRP_BYTE    = 2'b00;
  localparam logic [1:0] GRP_BIT     = 2'b01;
  localparam logic [1:0] GRP_CONTROL = 2'b10;
  localparam logic [1:0] GRP_LITERAL = 2'b11;

  // byte-oriented operations, bits 11..8
  localparam logic [3:0] BYTE_MISC   = 4'h0;
  localparam logic [3:0] BYTE_CLR    = 4'h1;
  localparam logic [3:0] BYTE_SUBWF  = 4'h2;
  localparam logic [3:0] BYTE_DECF   = 4'h3;
  localparam logic [3:0] BYTE_IORWF  = 4'h4;
  localparam logic [3:0] BYTE_ANDWF  = 4'h5;
  localparam logic [3:0] BYTE_XORWF  = 4'h6;
  localparam logic [3:0] BYTE_ADDWF  = 4'h7;
  localparam logic [3:0] BYTE_MOVF   = 4'h8;
  localparam logic [3:0] BYTE_COMF   = 4'h9;
  localparam logic [3:0] BYTE_INCF   = 4'hA;
  localparam logic [3:0] BYTE_DECFSZ = 4'hB;
  localparam logic [3:0] BYTE_RRF    = 4'hC;
  localparam logic [3:0] BYTE_RLF    = 4'hD;
  localparam logic [3:0] BYTE_SWAPF  = 4'hE;
  localparam logic [3:0] BYTE_INCFSZ = 4'hF;

  // misc encodings inside the byte group
  localparam logic [13:0] INSTR_RETURN = 14'h0008;
  localparam logic [13:0] INSTR_RETFIE = 14'h0009;

  // bit-oriented operations, bits 11..10
  localparam logic [1:0] BIT_BCF   = 2'b00;
  localparam logic [1:0] BIT_BSF   = 2'b01;
  localparam logic [1:0] BIT_BTFSC = 2'b10;
  localparam logic [1:0] BIT_BTFSS = 2'b11;

  // control group, bit 11
  localparam logic CTL_CALL = 1'b0;

  // literal group, bits 11..10
  localparam logic [1:0] LIT_MOVLW = 2'b00;
  localparam logic [1:0] LIT_RETLW = 2'b01;
  localparam logic [1:0] LIT_LOGIC = 2'b10;
  localparam logic [1:0] LIT_ARITH = 2'b11;

  // logic literal ops, bits 9..8
  localparam logic [1:0] LOG_IORLW = 2'b00;
  localparam logic [1:0] LOG_ANDLW = 2'b01;
  localparam logic [1:0] LOG_XORLW = 2'b10;
  localparam logic [1:0] LOG_NOP   = 2'b11;

  // arithmetic literal ops, bit 9
  localparam logic ARI_SUBLW = 1'b0;

  // flag positions in status
  localparam int FLAG_C  = 0;
  localparam int FLAG_DC = 1;
  localparam int FLAG_Z  = 2;

  localparam logic [1:0] CYC_ONE = 2'd1;
  localparam logic [1:0] CYC_TWO = 2'd2;

  typedef struct packed {
    logic [12:0] next_pc;
    logic        file_we;
    logic [6:0]  file_addr;
    logic [7:0]  file_data;
    logic [7:0]  w_value;
    logic [2:0]  status_out;
    logic [1:0]  cycles;
    logic        gie_set;
  } result_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [12:0] push_addr;
  } stk_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/mie_if.sv
// ----------------------------------------------------------------------------
// mie_if: stream channels of the execute block
// valid/ready channels for instruction beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface mie_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] instr;
  logic [7:0]  file_value;
  logic [2:0]  status_in;
  logic [1:0]  page_bits;

  modport source (output valid, output instr, output file_value, output status_in,
                  output page_bits, input ready);
  modport sink   (input valid, input instr, input file_value, input status_in,
                  input page_bits, output ready);
endinterface

interface mie_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] next_pc;
  logic        file_we;
  logic [6:0]  file_addr;
  logic [7:0]  file_data;
  logic [7:0]  w_value;
  logic [2:0]  status_out;
  logic [1:0]  cycles;
  logic        gie_set;

  modport source (output valid, output next_pc, output file_we, output file_addr,
                  output file_data, output w_value, output status_out, output cycles,
                  output gie_set, input ready);
  modport sink   (input valid, input next_pc, input file_we, input file_addr,
                  input file_data, input w_value, input status_out, input cycles,
                  input gie_set, output ready);
endinterface

`default_nettype wire

FILE: rtl/mie_alu.sv
// ----------------------------------------------------------------------------
// mie_alu: single-pass instruction execute
// decodes one instruction, computes byte alu result, flags, write-back,
// next program counter and return stack requests
// ----------------------------------------------------------------------------
`default_nettype none

module mie_alu (
  input  wire logic [13:0]        instr,
  input  wire logic [7:0]         file_value,
  input  wire logic [2:0]         status_in,
  input  wire logic [1:0]         page_bits,
  input  wire logic [7:0]         w_cur,
  input  wire logic [12:0]        pc_cur,
  input  wire logic [12:0]        stack_top,
  output mie_pkg::result_t        res,
  output mie_pkg::stk_ctrl_t      stk
);
  import mie_pkg::*;

  logic [1:0]  grp;
  logic [3:0]  sub_op;
  logic        dest_f;
  logic [7:0]  k8;
  logic [7:0]  opnd;
  logic [8:0]  sum9;
  logic [8:0]  diff9;
  logic [4:0]  half_sum;
  logic        half_ge;
  logic [7:0]  inc_v;
  logic [7:0]  dec_v;
  logic [7:0]  bit_mask;
  logic [12:0] pc_inc;
  logic [12:0] pc_skip;
  logic [7:0]  r;
  logic        to_dest;
  logic [7:0]  w_n;
  logic [2:0]  st;

  assign grp      = instr[13:12];
  assign sub_op   = instr[11:8];
  assign dest_f   = instr[7];
  assign k8       = instr[7:0];
  // shared adder operand: literal for the literal group, file value otherwise
  assign opnd     = (grp == GRP_LITERAL) ? k8 : file_value;
  assign sum9     = {1'b0, opnd} + {1'b0, w_cur};
  assign diff9    = {1'b0, opnd} - {1'b0, w_cur};
  assign half_sum = {1'b0, opnd[3:0]} + {1'b0, w_cur[3:0]};
  assign half_ge  = (opnd[3:0] >= w_cur[3:0]);
  assign inc_v    = file_value + 8'd1;
  assign dec_v    = file_value - 8'd1;
  assign bit_mask = 8'd1 << instr[9:7];
  assign pc_inc   = pc_cur + 13'd1;
  assign pc_skip  = pc_cur + 13'd2;

  always_comb begin
    r             = '0;
    to_dest       = 1'b0;
    w_n           = w_cur;
    st            = status_in;
    res.next_pc   = pc_inc;
    res.file_we   = 1'b0;
    res.file_data = '0;
    res.cycles    = CYC_ONE;
    res.gie_set   = 1'b0;
    stk.push      = 1'b0;
    stk.pop       = 1'b0;
    stk.push_addr = pc_inc;

    unique case (grp)
      GRP_BYTE: begin
        unique case (sub_op)
          BYTE_MISC: begin
            if (dest_f) begin
              res.file_we   = 1'b1;
              res.file_data = w_cur;
            end else if (instr == INSTR_RETURN || instr == INSTR_RETFIE) begin
              stk.pop     = 1'b1;
              res.next_pc = stack_top;
              res.cycles  = CYC_TWO;
              res.gie_set = (instr == INSTR_RETFIE);
            end
          end
          BYTE_CLR: begin
            if (dest_f) res.file_we = 1'b1;
            else w_n = '0;
            st[FLAG_Z] = 1'b1;
          end
          BYTE_SUBWF: begin
            to_dest     = 1'b1;
            r           = diff9[7:0];
            st[FLAG_C]  = ~diff9[8];
            st[FLAG_DC] = half_ge;
            st[FLAG_Z]  = (diff9[7:0] == 8'd0);
          end
          BYTE_DECF: begin
            to_dest    = 1'b1;
            r          = dec_v;
            st[FLAG_Z] = (dec_v == 8'd0);
          end
          BYTE_IORWF: begin
            to_dest    = 1'b1;
            r          = file_value | w_cur;
            st[FLAG_Z] = ((file_value | w_cur) == 8'd0);
          end
          BYTE_ANDWF: begin
            to_dest    = 1'b1;
            r          = file_value & w_cur;
            st[FLAG_Z] = ((file_value & w_cur) == 8'd0);
          end
          BYTE_XORWF: begin
            to_dest    = 1'b1;
            r          = file_value ^ w_cur;
            st[FLAG_Z] = ((file_value ^ w_cur) == 8'd0);
          end
          BYTE_ADDWF: begin
            to_dest     = 1'b1;
            r           = sum9[7:0];
            st[FLAG_C]  = sum9[8];
            st[FLAG_DC] = half_sum[4];
            st[FLAG_Z]  = (sum9[7:0] == 8'd0);
          end
          BYTE_MOVF: begin
            to_dest    = 1'b1;
            r          = file_value;
            st[FLAG_Z] = (file_value == 8'd0);
          end
          BYTE_COMF: begin
            to_dest    = 1'b1;
            r          = ~file_value;
            st[FLAG_Z] = (file_value == 8'hFF);
          end
          BYTE_INCF: begin
            to_dest    = 1'b1;
            r          = inc_v;
            st[FLAG_Z] = (inc_v == 8'd0);
          end
          BYTE_DECFSZ: begin
            to_dest = 1'b1;
            r       = dec_v;
            if (dec_v == 8'd0) begin
              res.next_pc = pc_skip;
              res.cycles  = CYC_TWO;
            end
          end
          BYTE_RRF: begin
            to_dest    = 1'b1;
            r          = {status_in[FLAG_C], file_value[7:1]};
            st[FLAG_C] = file_value[0];
          end
          BYTE_RLF: begin
            to_dest    = 1'b1;
            r          = {file_value[6:0], status_in[FLAG_C]};
            st[FLAG_C] = file_value[7];
          end
          BYTE_SWAPF: begin
            to_dest = 1'b1;
            r       = {file_value[3:0], file_value[7:4]};
          end
          BYTE_INCFSZ: begin
            to_dest = 1'b1;
            r       = inc_v;
            if (inc_v == 8'd0) begin
              res.next_pc = pc_skip;
              res.cycles  = CYC_TWO;
            end
          end
        endcase
      end
      GRP_BIT: begin
        unique case (instr[11:10])
          BIT_BCF: begin
            res.file_we   = 1'b1;
            res.file_data = file_value & ~bit_mask;
          end
          BIT_BSF: begin
            res.file_we   = 1'b1;
            res.file_data = file_value | bit_mask;
          end
          BIT_BTFSC: begin
            if ((file_value & bit_mask) == 8'd0) begin
              res.next_pc = pc_skip;
              res.cycles  = CYC_TWO;
            end
          end
          BIT_BTFSS: begin
            if ((file_value & bit_mask) != 8'd0) begin
              res.next_pc = pc_skip;
              res.cycles  = CYC_TWO;
            end
          end
        endcase
      end
      GRP_CONTROL: begin
        stk.push    = (instr[11] == CTL_CALL);
        res.next_pc = {page_bits, instr[10:0]};
        res.cycles  = CYC_TWO;
      end
      GRP_LITERAL: begin
        unique case (instr[11:10])
          LIT_MOVLW: w_n = k8;
          LIT_RETLW: begin
            w_n         = k8;
            stk.pop     = 1'b1;
            res.next_pc = stack_top;
            res.cycles  = CYC_TWO;
          end
          LIT_LOGIC: begin
            unique case (instr[9:8])
              LOG_IORLW: w_n = w_cur | k8;
              LOG_ANDLW: w_n = w_cur & k8;
              LOG_XORLW: w_n = w_cur ^ k8;
              LOG_NOP:   w_n = w_cur;
            endcase
            if (instr[9:8] != LOG_NOP) st[FLAG_Z] = (w_n == 8'd0);
          end
          LIT_ARITH: begin
            if (instr[9] == ARI_SUBLW) begin
              w_n         = diff9[7:0];
              st[FLAG_C]  = ~diff9[8];
              st[FLAG_DC] = half_ge;
              st[FLAG_Z]  = (diff9[7:0] == 8'd0);
            end else begin
              w_n         = sum9[7:0];
              st[FLAG_C]  = sum9[8];
              st[FLAG_DC] = half_sum[4];
              st[FLAG_Z]  = (sum9[7:0] == 8'd0);
            end
          end
        endcase
      end
    endcase

    if (to_dest) begin
      if (dest_f) begin
        res.file_we   = 1'b1;
        res.file_data = r;
      end else begin
        w_n = r;
      end
    end

    res.file_addr  = instr[6:0];
    res.w_value    = w_n;
    res.status_out = st;
  end

endmodule

`default_nettype wire

FILE: rtl/mie_stack.sv
// ----------------------------------------------------------------------------
// mie_stack: circular return address stack
// push at the pointer, pop from the entry below it, pointer wraps at depth
// ----------------------------------------------------------------------------
`default_nettype none

module mie_stack #(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  mie_pkg::stk_ctrl_t      ctrl,
  output logic [12:0]             top_addr
);
  import mie_pkg::*;

  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);

  logic [12:0]      entry_r [STACK_DEPTH];
  logic [PTR_W-1:0] sp_r;
  logic [PTR_W-1:0] sp_nxt;
  logic [PTR_W-1:0] sp_inc;
  logic [PTR_W-1:0] sp_dec;

  assign sp_inc   = (sp_r == PTR_LAST) ? '0 : sp_r + PTR_W'(1);
  assign sp_dec   = (sp_r == '0) ? PTR_LAST : sp_r - PTR_W'(1);
  // entry that a pop returns
  assign top_addr = entry_r[sp_dec];

  always_comb begin
    sp_nxt = sp_r;
    if (en && ctrl.push) sp_nxt = sp_inc;
    else if (en && ctrl.pop) sp_nxt = sp_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctrl.push) begin
      entry_r[sp_r] <= ctrl.push_addr;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/midrange_14bit_instruction_execute.sv
// path: input register, then execute logic, then output register to the result beat
// throughput: one instruction per cycle while the result channel is not stalled;
//   W, PC and the stack pointer are updated in the same pass that produces the
//   result, so the next beat already sees them
// reset: synchronous active low, clears W, PC, stack pointer and both valids;
//   return stack entries hold no reset value until pushed
// ----------------------------------------------------------------------------
// midrange_14bit_instruction_execute: 14-bit instruction execute stage
// input register, single-pass execute logic and output register, with the
// working register, program counter and circular return stack kept here
// ----------------------------------------------------------------------------
`default_nettype none

module midrange_14bit_instruction_execute #(
  parameter int STACK_DEPTH = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mie_in_if.sink     in_ch,
  mie_out_if.source  out_ch
);
  import mie_pkg::*;

  // input register
  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [13:0] instr_r;
  logic [7:0]  file_value_r;
  logic [2:0]  status_in_r;
  logic [1:0]  page_bits_r;

  // architectural state
  logic [7:0]  w_r;
  logic [12:0] pc_r;

  // output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     out_r;

  // execute results
  result_t     res;
  stk_ctrl_t   stk;
  logic [12:0] stack_top;

  logic        in_fire;
  logic        advance;
  logic        commit;

  // output register frees up when empty or being drained
  assign advance      = !out_valid_r || out_ch.ready;
  // input register takes a beat when empty or moving forward
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  // an instruction executes and updates state when it moves to the output
  assign commit       = in_valid_r && advance;

  assign in_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? in_valid_r : out_valid_r;

  mie_alu u_alu (
    .instr      (instr_r),
    .file_value (file_value_r),
    .status_in  (status_in_r),
    .page_bits  (page_bits_r),
    .w_cur      (w_r),
    .pc_cur     (pc_r),
    .stack_top  (stack_top),
    .res        (res),
    .stk        (stk)
  );

  mie_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (commit),
    .ctrl     (stk),
    .top_addr (stack_top)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      w_r         <= '0;
      pc_r        <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        w_r  <= res.w_value;
        pc_r <= res.next_pc;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r      <= in_ch.instr;
      file_value_r <= in_ch.file_value;
      status_in_r  <= in_ch.status_in;
      page_bits_r  <= in_ch.page_bits;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  // result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_pc    = out_r.next_pc;
  assign out_ch.file_we    = out_r.file_we;
  assign out_ch.file_addr  = out_r.file_addr;
  assign out_ch.file_data  = out_r.file_data;
  assign out_ch.w_value    = out_r.w_value;
  assign out_ch.status_out = out_r.status_out;
  assign out_ch.cycles     = out_r.cycles;
  assign out_ch.gie_set    = out_r.gie_set;

`ifndef ASSERT_OFF
  // a pending result always carries a legal cycle count
  a_cycles_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.cycles == CYC_ONE || out_r.cycles == CYC_TWO))
    else $error("result cycle count out of range");

  // interrupt re-enable only comes from a return, whose result carries CYC_TWO
  a_gie_return: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.gie_set) |-> (out_r.cycles == CYC_TWO))
    else $error("gie_set on a non-return result");

  // no write strobe means no write data
  a_data_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.file_we) |-> (out_r.file_data == 8'd0))
    else $error("file_data driven without file_we");

  // the program counter follows the last committed result
  a_pc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (pc_r == out_r.next_pc))
    else $error("program counter out of step with result");
`endif

endmodule

`default_nettype wire

FILE: test/mie_exec_checker.sv
// ----------------------------------------------------------------------------
// mie_exec_checker: result checker for the 14-bit instruction execute stage
// watches both channels, runs its own copy of W, PC and the return stack
// on every accepted instruction beat and compares each result beat in order
// ----------------------------------------------------------------------------
module mie_exec_checker #(
  parameter int STACK_DEPTH = 8
) (
  input  logic clk,
  input  logic rst_n,
  mie_in_if    in_ch,
  mie_out_if   out_ch,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   branches_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  import mie_pkg::*;

  logic [7:0]  w_acc;
  logic [12:0] pc;
  logic [12:0] ret_stack [STACK_DEPTH];
  int          sp;
  result_t     pending_results [$];

  function automatic void push_return(logic [12:0] addr);
    ret_stack[sp] = addr;
    sp = (sp + 1) % STACK_DEPTH;
  endfunction

  function automatic logic [12:0] pop_return();
    sp = (sp == 0) ? STACK_DEPTH - 1 : sp - 1;
    return ret_stack[sp];
  endfunction

  // executes one instruction against the local state and returns its result
  function automatic result_t execute_instr(logic [13:0] instr, logic [7:0] fv,
                                            logic [2:0] st_in, logic [1:0] page);
    result_t     res;
    logic [7:0]  w;
    logic [7:0]  k8;
    logic [7:0]  r;
    logic [7:0]  data;
    logic [7:0]  mask;
    logic [8:0]  sum;
    logic [4:0]  nib;
    logic [2:0]  st;
    logic [12:0] nxt;
    logic [12:0] skp;
    logic [1:0]  cyc;
    logic        we;
    logic        gie;
    logic        to_dest;
    logic        d;
    logic        cin;
    w       = w_acc;
    st      = st_in;
    k8      = instr[7:0];
    d       = instr[7];
    cin     = st_in[FLAG_C];
    nxt     = pc + 13'd1;
    skp     = pc + 13'd2;
    mask    = 8'd1 << instr[9:7];
    r       = '0;
    data    = '0;
    we      = 1'b0;
    gie     = 1'b0;
    to_dest = 1'b0;
    cyc     = CYC_ONE;
    case (instr[13:12])
      GRP_BYTE: begin
        if (instr[11:8] == BYTE_MISC) begin
          if (d) begin
            we   = 1'b1;
            data = w;
          end else if (instr == INSTR_RETURN || instr == INSTR_RETFIE) begin
            nxt = pop_return();
            cyc = CYC_TWO;
            gie = (instr == INSTR_RETFIE);
          end
        end else if (instr[11:8] == BYTE_CLR) begin
          if (d) we = 1'b1;
          else w = 8'h00;
          st[FLAG_Z] = 1'b1;
        end else begin
          to_dest = 1'b1;
          case (instr[11:8])
            BYTE_SUBWF: begin
              r           = fv - w;
              st[FLAG_C]  = (fv >= w);
              st[FLAG_DC] = (fv[3:0] >= w[3:0]);
              st[FLAG_Z]  = (r == 8'h00);
            end
            BYTE_DECF: begin
              r          = fv - 8'd1;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_IORWF: begin
              r          = fv | w;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_ANDWF: begin
              r          = fv & w;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_XORWF: begin
              r          = fv ^ w;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_ADDWF: begin
              sum         = {1'b0, fv} + {1'b0, w};
              nib         = {1'b0, fv[3:0]} + {1'b0, w[3:0]};
              r           = sum[7:0];
              st[FLAG_C]  = sum[8];
              st[FLAG_DC] = nib[4];
              st[FLAG_Z]  = (r == 8'h00);
            end
            BYTE_MOVF: begin
              r          = fv;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_COMF: begin
              r          = ~fv;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_INCF: begin
              r          = fv + 8'd1;
              st[FLAG_Z] = (r == 8'h00);
            end
            BYTE_DECFSZ: begin
              r = fv - 8'd1;
              if (r == 8'h00) begin
                nxt = skp;
                cyc = CYC_TWO;
              end
            end
            BYTE_RRF: begin
              r          = {cin, fv[7:1]};
              st[FLAG_C] = fv[0];
            end
            BYTE_RLF: begin
              r          = {fv[6:0], cin};
              st[FLAG_C] = fv[7];
            end
            BYTE_SWAPF: r = {fv[3:0], fv[7:4]};
            default: begin
              r = fv + 8'd1;
              if (r == 8'h00) begin
                nxt = skp;
                cyc = CYC_TWO;
              end
            end
          endcase
        end
      end
      GRP_BIT: begin
        case (instr[11:10])
          BIT_BCF: begin
            we   = 1'b1;
            data = fv & ~mask;
          end
          BIT_BSF: begin
            we   = 1'b1;
            data = fv | mask;
          end
          BIT_BTFSC: begin
            if ((fv & mask) == 8'h00) begin
              nxt = skp;
              cyc = CYC_TWO;
            end
          end
          default: begin
            if ((fv & mask) != 8'h00) begin
              nxt = skp;
              cyc = CYC_TWO;
            end
          end
        endcase
      end
      GRP_CONTROL: begin
        if (instr[11] == CTL_CALL) push_return(nxt);
        nxt = {page, instr[10:0]};
        cyc = CYC_TWO;
      end
      default: begin
        case (instr[11:10])
          LIT_MOVLW: w = k8;
          LIT_RETLW: begin
            w   = k8;
            nxt = pop_return();
            cyc = CYC_TWO;
          end
          LIT_LOGIC: begin
            if (instr[9:8] != LOG_NOP) begin
              case (instr[9:8])
                LOG_IORLW: w = w | k8;
                LOG_ANDLW: w = w & k8;
                default:   w = w ^ k8;
              endcase
              st[FLAG_Z] = (w == 8'h00);
            end
          end
          default: begin
            if (instr[9] == ARI_SUBLW) begin
              r           = k8 - w;
              st[FLAG_C]  = (k8 >= w);
              st[FLAG_DC] = (k8[3:0] >= w[3:0]);
            end else begin
              sum         = {1'b0, k8} + {1'b0, w};
              nib         = {1'b0, k8[3:0]} + {1'b0, w[3:0]};
              r           = sum[7:0];
              st[FLAG_C]  = sum[8];
              st[FLAG_DC] = nib[4];
            end
            st[FLAG_Z] = (r == 8'h00);
            w          = r;
          end
        endcase
      end
    endcase
    if (to_dest) begin
      if (d) begin
        we   = 1'b1;
        data = r;
      end else begin
        w = r;
      end
    end
    w_acc = w;
    pc    = nxt;
    res.next_pc    = nxt;
    res.file_we    = we;
    res.file_addr  = instr[6:0];
    res.file_data  = we ? data : 8'h00;
    res.w_value    = w;
    res.status_out = st;
    res.cycles     = cyc;
    res.gie_set    = gie;
    return res;
  endfunction

  function automatic int check_field(string name, logic [12:0] exp_v, logic [12:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      errs;
    if (!rst_n) begin
      w_acc           = 8'h00;
      pc              = 13'h0000;
      sp              = 0;
      mismatches      = 0;
      results_checked = 0;
      branches_taken  = 0;
      pending_results.delete();
      outstanding     = 0;
    end else begin
      // results first, so a beat can never match an instruction of the same edge
      if (out_ch.valid && out_ch.ready) begin
        got.next_pc    = out_ch.next_pc;
        got.file_we    = out_ch.file_we;
        got.file_addr  = out_ch.file_addr;
        got.file_data  = out_ch.file_data;
        got.w_value    = out_ch.w_value;
        got.status_out = out_ch.status_out;
        got.cycles     = out_ch.cycles;
        got.gie_set    = out_ch.gie_set;
        if (pending_results.size() == 0) begin
          $error("result beat with no instruction pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          errs = 0;
          errs += check_field("next_pc", want.next_pc, got.next_pc);
          errs += check_field("file_we", 13'(want.file_we), 13'(got.file_we));
          errs += check_field("file_addr", 13'(want.file_addr), 13'(got.file_addr));
          errs += check_field("file_data", 13'(want.file_data), 13'(got.file_data));
          errs += check_field("w_value", 13'(want.w_value), 13'(got.w_value));
          errs += check_field("status_out", 13'(want.status_out), 13'(got.status_out));
          errs += check_field("cycles", 13'(want.cycles), 13'(got.cycles));
          errs += check_field("gie_set", 13'(want.gie_set), 13'(got.gie_set));
          if (errs != 0) mismatches++;
          results_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = execute_instr(in_ch.instr, in_ch.file_value, in_ch.status_in, in_ch.page_bits);
        if (want.cycles == CYC_TWO) branches_taken++;
        pending_results.push_back(want);
      end
      outstanding = pending_results.size();
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the 14-bit instruction execute stage
// drives instruction beats (a directed pass over every operation, then
// random call chains, random blocks and raw words) under varying idle and
// stall patterns; the checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mie_pkg::*;

  localparam int STACK_DEPTH     = 8;
  localparam int RANDOM_BEATS    = 410;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;

  // misc byte-group encodings that must behave as nop
  localparam logic [13:0] INSTR_OPTION = 14'h0062;
  localparam logic [13:0] INSTR_SLEEP  = 14'h0063;
  localparam logic [13:0] INSTR_CLRWDT = 14'h0064;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  mie_in_if  in_ch ();
  mie_out_if out_ch ();

  int mismatches;
  int outstanding;
  int results_checked;
  int branches_taken;

  midrange_14bit_instruction_execute #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  mie_exec_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .branches_taken (branches_taken)
  );

  // idle / stall knobs, in percent
  int source_idle_pct = 0;
  int sink_stall_pct  = 0;
  bit hold_off_request = 1'b0;

  // issue-side view of the return stack, only to keep pops on pushed entries
  int gen_sp = 0;
  bit stack_written [STACK_DEPTH];
  int beats_sent  = 0;
  int calls_sent  = 0;
  int pops_sent   = 0;

  function automatic bit is_pop(logic [13:0] instr);
    return (instr == INSTR_RETURN) || (instr == INSTR_RETFIE) ||
           (instr[13:10] == {GRP_LITERAL, LIT_RETLW});
  endfunction

  function automatic bit is_call(logic [13:0] instr);
    return (instr[13:12] == GRP_CONTROL) && (instr[11] == CTL_CALL);
  endfunction

  function automatic logic [13:0] byte_op(logic [3:0] op, logic d, logic [6:0] f);
    return {GRP_BYTE, op, d, f};
  endfunction

  function automatic logic [13:0] bit_op(logic [1:0] op, logic [2:0] b, logic [6:0] f);
    return {GRP_BIT, op, b, f};
  endfunction

  // file values lean on the corners that make zero flags and skips fire
  function automatic logic [7:0] random_file_value();
    logic [7:0] v;
    case ($urandom_range(11))
      0:       v = 8'h00;
      1:       v = 8'h01;
      2:       v = 8'hFF;
      3:       v = 8'h80;
      4:       v = 8'h7F;
      5:       v = 8'h0F;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [13:0] random_instr();
    logic [13:0] word;
    int          pick;
    word = 14'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) word[13:12] = GRP_BYTE;
    else if (pick < 60) word[13:12] = GRP_BIT;
    else if (pick < 68) word[13:12] = GRP_CONTROL;
    else if (pick < 90) word[13:12] = GRP_LITERAL;
    else if (pick < 95) word = ($urandom_range(1) == 1) ? INSTR_RETURN : INSTR_RETFIE;
    // the rest stays a raw 14-bit word
    return word;
  endfunction

  // body of a subroutine: anything but a jump or a return
  function automatic logic [13:0] body_instr();
    logic [13:0] word;
    do word = random_instr();
    while (is_pop(word) || word[13:12] == GRP_CONTROL);
    return word;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_instr(logic [13:0] instr, logic [7:0] fv, logic [2:0] st,
                            logic [1:0] pg);
    logic [13:0] word;
    int          slot;
    word = instr;
    slot = (gen_sp == 0) ? STACK_DEPTH - 1 : gen_sp - 1;
    // a return into a stack entry never pushed since reset turns into a call
    if (is_pop(word) && !stack_written[slot]) word = {GRP_CONTROL, CTL_CALL, word[10:0]};
    if (is_pop(word)) begin
      gen_sp = slot;
      pops_sent++;
    end else if (is_call(word)) begin
      stack_written[gen_sp] = 1'b1;
      gen_sp = (gen_sp + 1) % STACK_DEPTH;
      calls_sent++;
    end
    while ($urandom_range(99) < source_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.instr      <= word;
    in_ch.file_value <= fv;
    in_ch.status_in  <= st;
    in_ch.page_bits  <= pg;
    do @(posedge clk);
    while (!in_ch.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(logic [13:0] instr);
    send_instr(instr, random_file_value(), 3'($urandom), 2'($urandom));
  endtask

  // nested calls with short bodies, then the matching returns
  task automatic call_chain(int depth);
    repeat (depth) begin
      send_random({GRP_CONTROL, CTL_CALL, 11'($urandom)});
      repeat ($urandom_range(2)) send_random(body_instr());
    end
    repeat (depth) begin
      case ($urandom_range(2))
        0:       send_random(INSTR_RETURN);
        1:       send_random(INSTR_RETFIE);
        default: send_random({GRP_LITERAL, LIT_RETLW, 10'($urandom)});
      endcase
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog: any long stretch without a beat on either channel is a hang
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $error("no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int step;
    int kind;
    int directed_beats;
    bit hold_off_done;
    in_ch.valid      = 1'b0;
    in_ch.instr      = '0;
    in_ch.file_value = '0;
    in_ch.status_in  = '0;
    in_ch.page_bits  = '0;
    phase            = -1;
    hold_off_done    = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed pass: every operation at its corners ----
    // W = ff, then addwf ff + 01 carries out of both the byte and the nibble
    send_instr({GRP_LITERAL, LIT_MOVLW, 2'b00, 8'hFF}, 8'h00, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_ADDWF, 1'b1, 7'h7F), 8'h01, 3'b000, 2'b00);
    // 00 - ff borrows
    send_instr(byte_op(BYTE_SUBWF, 1'b0, 7'h00), 8'h00, 3'b111, 2'b00);
    send_instr(byte_op(BYTE_DECF, 1'b1, 7'h01), 8'h01, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_IORWF, 1'b0, 7'h02), 8'h00, 3'b100, 2'b00);
    send_instr(byte_op(BYTE_ANDWF, 1'b1, 7'h03), 8'hFF, 3'b111, 2'b00);
    send_instr(byte_op(BYTE_XORWF, 1'b0, 7'h04), 8'hFF, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_MOVF, 1'b1, 7'h05), 8'h00, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_COMF, 1'b0, 7'h06), 8'hFF, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_INCF, 1'b1, 7'h07), 8'hFF, 3'b000, 2'b00);
    // decrement and increment to zero take the skip
    send_instr(byte_op(BYTE_DECFSZ, 1'b1, 7'h08), 8'h01, 3'b000, 2'b00);
    // rotates pull the old carry in and push the dropped bit out
    send_instr(byte_op(BYTE_RRF, 1'b1, 7'h09), 8'h01, 3'b001, 2'b00);
    send_instr(byte_op(BYTE_RLF, 1'b0, 7'h0A), 8'h80, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_SWAPF, 1'b1, 7'h0B), 8'hA5, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_INCFSZ, 1'b0, 7'h0C), 8'hFF, 3'b000, 2'b00);
    send_instr(bit_op(BIT_BTFSC, 3'd7, 7'h7F), 8'h7F, 3'b000, 2'b00);
    send_instr(bit_op(BIT_BTFSS, 3'd0, 7'h00), 8'h01, 3'b000, 2'b00);
    send_instr(bit_op(BIT_BCF, 3'd7, 7'h00), 8'hFF, 3'b000, 2'b00);
    send_instr(bit_op(BIT_BSF, 3'd0, 7'h7F), 8'h00, 3'b000, 2'b00);
    // clear of the file register, then of W
    send_instr(byte_op(BYTE_CLR, 1'b1, 7'h2A), 8'h33, 3'b000, 2'b00);
    send_instr(byte_op(BYTE_CLR, 1'b0, 7'h00), 8'h33, 3'b011, 2'b00);
    send_instr(byte_op(BYTE_MISC, 1'b1, 7'h7F), 8'h00, 3'b000, 2'b00);
    send_instr(INSTR_OPTION, 8'h12, 3'b101, 2'b00);
    send_instr(INSTR_SLEEP, 8'h34, 3'b010, 2'b00);
    send_instr(INSTR_CLRWDT, 8'h56, 3'b111, 2'b00);
    // literal arithmetic and logic, W starts at zero here
    send_instr({GRP_LITERAL, LIT_ARITH, ARI_SUBLW, 1'b0, 8'h00}, 8'h00, 3'b000, 2'b00);
    send_instr({GRP_LITERAL, LIT_ARITH, ~ARI_SUBLW, 1'b0, 8'hFF}, 8'h00, 3'b000, 2'b00);
    send_instr({GRP_LITERAL, LIT_LOGIC, LOG_XORLW, 8'hFF}, 8'h00, 3'b000, 2'b00);
    send_instr({GRP_LITERAL, LIT_LOGIC, LOG_IORLW, 8'h00}, 8'h00, 3'b000, 2'b00);
    send_instr({GRP_LITERAL, LIT_LOGIC, LOG_ANDLW, 8'h00}, 8'h00, 3'b000, 2'b00);
    // undefined literal encoding
    send_instr({GRP_LITERAL, LIT_LOGIC, LOG_NOP, 8'h5A}, 8'h00, 3'b110, 2'b00);
    // goto the last address, then a skip from there wraps the pc
    send_instr({GRP_CONTROL, ~CTL_CALL, 11'h7FF}, 8'h00, 3'b000, 2'b11);
    send_instr(byte_op(BYTE_INCFSZ, 1'b1, 7'h0D), 8'hFF, 3'b000, 2'b00);
    // calls and every kind of return
    send_instr({GRP_CONTROL, CTL_CALL, 11'h123}, 8'h00, 3'b000, 2'b01);
    send_instr({GRP_CONTROL, CTL_CALL, 11'h456}, 8'h00, 3'b000, 2'b10);
    send_instr({GRP_CONTROL, CTL_CALL, 11'h000}, 8'h00, 3'b000, 2'b00);
    send_instr({GRP_LITERAL, LIT_RETLW, 2'b00, 8'hFF}, 8'h00, 3'b000, 2'b00);
    send_instr(INSTR_RETFIE, 8'h00, 3'b000, 2'b00);
    send_instr(INSTR_RETURN, 8'h00, 3'b000, 2'b00);
    directed_beats = beats_sent;

    // ---- random part ----
    // one chain deeper than the stack first, so it wraps and overwrites
    call_chain(STACK_DEPTH + 2);
    while (beats_sent - directed_beats < RANDOM_BEATS) begin
      step = (beats_sent - directed_beats) * 4 / RANDOM_BEATS;
      if (step != phase) begin
        phase = step;
        if (phase == 2) begin
          // sender pauses until the block has handed back everything
          in_ch.valid <= 1'b0;
          do @(negedge clk);
          while (outstanding != 0);
        end
        case (phase)
          0: begin
            source_idle_pct = 0;
            sink_stall_pct  = 0;
          end
          1: begin
            source_idle_pct = 50;
            sink_stall_pct  = 0;
          end
          2: begin
            source_idle_pct = 0;
            sink_stall_pct  = 50;
          end
          default: begin
            source_idle_pct = 28;
            sink_stall_pct  = 28;
          end
        endcase
      end
      // long result hold-off while the sender keeps offering beats
      if (phase == 0 && !hold_off_done && beats_sent - directed_beats >= 40) begin
        hold_off_request = 1'b1;
        hold_off_done    = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 60) begin
        call_chain(($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 4));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) send_random(random_instr());
      end else begin
        // noise: raw words, stray returns included
        repeat ($urandom_range(1, 3)) send_random(14'($urandom));
      end
    end
    in_ch.valid <= 1'b0;

    // let the pipeline empty, then watch a little longer for stray beats
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d instruction beats (%0d directed), %0d results checked, %0d taken",
             beats_sent, directed_beats, results_checked, branches_taken);
    $display("stack traffic: %0d calls, %0d returns over a %0d-entry stack",
             calls_sent, pops_sent, STACK_DEPTH);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mie_pkg.sv
rtl/mie_if.sv
rtl/mie_alu.sv
rtl/mie_stack.sv
rtl/midrange_14bit_instruction_execute.sv
test/mie_exec_checker.sv
test/tb.sv
